### hw/rtl/hrp_pkg.sv
// shared types, codes and constant tables of the http request header parser
// no dependencies
package hrp_pkg;

  localparam int unsigned HEADER_BYTES_MAX = 1024;
  localparam int unsigned LimitW = 11;
  localparam logic [LimitW-1:0] LIMIT_RESET = 11'd1024;
  localparam logic [LimitW-1:0] LIMIT_MIN = 11'd8;
  localparam int unsigned TermLen = 4;

  localparam logic [4:0] NAME_LEN = 5'd16;
  localparam logic [3:0] PREFIX_LEN = 4'd9;
  localparam logic [3:0] PREFIX_FAILED = 4'd15;

  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_LF = 8'h0a;
  localparam logic [7:0] CHAR_SP = 8'h20;
  localparam logic [7:0] CHAR_QM = 8'h3f;
  localparam logic [7:0] CHAR_SLASH = 8'h2f;

  typedef enum logic [2:0] {
    PH_METHOD  = 3'd0,
    PH_TARGET  = 3'd1,
    PH_QUERY   = 3'd2,
    PH_VERSION = 3'd3,
    PH_HEADER  = 3'd4,
    PH_LENVAL  = 3'd5,
    PH_DISCARD = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    TAG_METHOD  = 3'd0,
    TAG_TARGET  = 3'd1,
    TAG_QUERY   = 3'd2,
    TAG_VERSION = 3'd3,
    TAG_LENVAL  = 3'd4,
    TAG_TEXT    = 3'd5,
    TAG_SEP     = 3'd6,
    TAG_DISCARD = 3'd7
  } tag_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_SEP   = 2'd1,
    ERR_LIMIT = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    ROOT_EMPTY = 2'd0,
    ROOT_SLASH = 2'd1,
    ROOT_OTHER = 2'd2
  } root_e;

  // per-request parse state, byte count kept separately
  typedef struct packed {
    phase_e      phase;
    logic [1:0]  term_pos;
    logic [4:0]  name_pos;
    logic        line_start;
    root_e       root;
    logic [3:0]  prefix_pos;
    err_e        held_err;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase:      PH_METHOD,
    term_pos:   2'd0,
    name_pos:   5'd0,
    line_start: 1'b1,
    root:       ROOT_EMPTY,
    prefix_pos: 4'd0,
    held_err:   ERR_NONE
  };

  // per-byte result of the tagger
  typedef struct packed {
    tag_e  tag;
    logic  done;
    err_e  err;
    logic  root;
    logic  cgi;
  } result_t;

  function automatic logic [7:0] len_name_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = "C";
      4'd1:    c = "o";
      4'd2:    c = "n";
      4'd3:    c = "t";
      4'd4:    c = "e";
      4'd5:    c = "n";
      4'd6:    c = "t";
      4'd7:    c = "-";
      4'd8:    c = "L";
      4'd9:    c = "e";
      4'd10:   c = "n";
      4'd11:   c = "g";
      4'd12:   c = "t";
      4'd13:   c = "h";
      4'd14:   c = ":";
      4'd15:   c = " ";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] cgi_prefix_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = "/";
      4'd1:    c = "c";
      4'd2:    c = "g";
      4'd3:    c = "i";
      4'd4:    c = "-";
      4'd5:    c = "b";
      4'd6:    c = "i";
      4'd7:    c = "n";
      4'd8:    c = "/";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### hw/rtl/hrp_if.sv
// valid/ready channel interfaces for header bytes in and tagged items out
// uses no package
interface hrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface hrp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] byte_tag;
  logic       request_done;
  logic [1:0] error_code;
  logic       target_is_root;
  logic       target_is_cgi;

  modport source (output valid, output byte_tag, output request_done, output error_code,
                  output target_is_root, output target_is_cgi, input ready);
  modport sink (input valid, input byte_tag, input request_done, input error_code,
                input target_is_root, input target_is_cgi, output ready);
endinterface

### hw/rtl/http_request_header_parser.sv
// top level of the http request header parser: apb register, byte pipeline
// depends on hrp_pkg, hrp_if (hrp_in_if, hrp_out_if) and hrp_tagger
//
//  channel  dir  handshake     payload
//  req_i    in   valid/ready   data_byte
//  tag_o    out  valid/ready   byte_tag, request_done, error_code, target_is_root/cgi
//  apb      in   psel/penable  header_limit at byte address 0
//
// one item per cycle sustained while tag_o is ready; an item taken passes through
// the input register, then the result register behind the tagger logic
// the per-request state updates once per byte, in a loop through the tagger and the state register
// reset clears the valid flags, parse state and byte count, and sets header_limit to 1024
// a stalled result register holds, and the input register refills behind it
module http_request_header_parser #(
  parameter int unsigned HeaderBytesMax = hrp_pkg::HEADER_BYTES_MAX
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  hrp_in_if.sink             req_i,
  hrp_out_if.source          tag_o
);

  localparam int unsigned CntW = $clog2(HeaderBytesMax + hrp_pkg::TermLen + 1);
  localparam int unsigned CmpW = ((CntW > hrp_pkg::LimitW) ? CntW : hrp_pkg::LimitW) + 1;
  localparam logic [CmpW-1:0] MaxCmp = CmpW'(HeaderBytesMax);

  logic [hrp_pkg::LimitW-1:0] limit_q;
  logic                       cfg_wr;

  logic                       in_vld_q;
  logic [7:0]                 in_byte_q;
  logic                       adv;

  hrp_pkg::state_t            state_q, state_d, tag_state;
  hrp_pkg::result_t           tag_res, res_d, res_q;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [CmpW-1:0]            cnt_next, lim_eff, lim_raw;
  logic                       overflow;
  logic                       out_vld_q;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {{(32 - hrp_pkg::LimitW){1'b0}}, limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= hrp_pkg::LIMIT_RESET;
    end else if (cfg_wr) begin
      limit_q <= pwdata[hrp_pkg::LimitW-1:0];
    end
  end

  // input register
  assign adv         = in_vld_q && (!out_vld_q || tag_o.ready);
  assign req_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_byte_q <= req_i.data_byte;
    end
  end

  hrp_tagger u_tagger (
    .state_i     (state_q),
    .data_byte_i (in_byte_q),
    .state_o     (tag_state),
    .result_o    (tag_res)
  );

  // limit clamp and overflow check
  always_comb begin
    lim_raw = CmpW'(limit_q);
    if (limit_q < hrp_pkg::LIMIT_MIN) begin
      lim_eff = CmpW'(hrp_pkg::LIMIT_MIN);
    end else if (lim_raw > MaxCmp) begin
      lim_eff = MaxCmp;
    end else begin
      lim_eff = lim_raw;
    end
    cnt_next = CmpW'(cnt_q) + CmpW'(1);
    overflow = (cnt_next >= lim_eff + CmpW'(hrp_pkg::TermLen));
  end

  always_comb begin
    if (overflow) begin
      res_d   = '{tag: hrp_pkg::TAG_DISCARD, done: 1'b1, err: hrp_pkg::ERR_LIMIT,
                  root: 1'b0, cgi: 1'b0};
      state_d = hrp_pkg::STATE_RESET;
      cnt_d   = '0;
    end else begin
      res_d   = tag_res;
      state_d = tag_state;
      cnt_d   = tag_res.done ? '0 : cnt_next[CntW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hrp_pkg::STATE_RESET;
      cnt_q   <= '0;
    end else if (adv) begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (tag_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign tag_o.valid          = out_vld_q;
  assign tag_o.byte_tag       = res_q.tag;
  assign tag_o.request_done   = res_q.done;
  assign tag_o.error_code     = res_q.err;
  assign tag_o.target_is_root = res_q.root;
  assign tag_o.target_is_cgi  = res_q.cgi;

endmodule

### hw/rtl/hrp_tagger.sv
// per-byte tagging and parse state update, purely combinational
// depends on hrp_pkg
module hrp_tagger (
  input  hrp_pkg::state_t  state_i,
  input  logic [7:0]       data_byte_i,
  output hrp_pkg::state_t  state_o,
  output hrp_pkg::result_t result_o
);

  logic            eol;
  logic            term_match;
  logic [7:0]      term_char;
  hrp_pkg::state_t st;
  hrp_pkg::tag_e   tag;

  assign eol = (data_byte_i == hrp_pkg::CHAR_CR) || (data_byte_i == hrp_pkg::CHAR_LF);

  always_comb begin
    st  = state_i;
    tag = hrp_pkg::TAG_DISCARD;
    unique case (state_i.phase)
      hrp_pkg::PH_METHOD: begin
        if (eol) begin
          st.held_err = hrp_pkg::ERR_SEP;
          st.phase    = hrp_pkg::PH_DISCARD;
          tag         = hrp_pkg::TAG_DISCARD;
        end else if (data_byte_i == hrp_pkg::CHAR_SP) begin
          st.phase = hrp_pkg::PH_TARGET;
          tag      = hrp_pkg::TAG_SEP;
        end else begin
          tag = hrp_pkg::TAG_METHOD;
        end
      end
      hrp_pkg::PH_TARGET: begin
        if (eol) begin
          st.held_err = hrp_pkg::ERR_SEP;
          st.phase    = hrp_pkg::PH_DISCARD;
          tag         = hrp_pkg::TAG_DISCARD;
        end else if (data_byte_i == hrp_pkg::CHAR_QM) begin
          st.phase = hrp_pkg::PH_QUERY;
          tag      = hrp_pkg::TAG_SEP;
        end else if (data_byte_i == hrp_pkg::CHAR_SP) begin
          st.phase = hrp_pkg::PH_VERSION;
          tag      = hrp_pkg::TAG_SEP;
        end else begin
          st.root = (state_i.root == hrp_pkg::ROOT_EMPTY && data_byte_i == hrp_pkg::CHAR_SLASH)
                    ? hrp_pkg::ROOT_SLASH : hrp_pkg::ROOT_OTHER;
          if (state_i.prefix_pos < hrp_pkg::PREFIX_LEN) begin
            st.prefix_pos = (data_byte_i == hrp_pkg::cgi_prefix_char(state_i.prefix_pos))
                            ? state_i.prefix_pos + 4'd1 : hrp_pkg::PREFIX_FAILED;
          end
          tag = hrp_pkg::TAG_TARGET;
        end
      end
      hrp_pkg::PH_QUERY: begin
        if (eol) begin
          st.held_err = hrp_pkg::ERR_SEP;
          st.phase    = hrp_pkg::PH_DISCARD;
          tag         = hrp_pkg::TAG_DISCARD;
        end else if (data_byte_i == hrp_pkg::CHAR_SP) begin
          st.phase = hrp_pkg::PH_VERSION;
          tag      = hrp_pkg::TAG_SEP;
        end else begin
          tag = hrp_pkg::TAG_QUERY;
        end
      end
      hrp_pkg::PH_VERSION, hrp_pkg::PH_LENVAL: begin
        if (eol) begin
          st.phase      = hrp_pkg::PH_HEADER;
          st.name_pos   = 5'd0;
          st.line_start = (data_byte_i == hrp_pkg::CHAR_LF);
          tag           = hrp_pkg::TAG_SEP;
        end else begin
          tag = (state_i.phase == hrp_pkg::PH_VERSION) ? hrp_pkg::TAG_VERSION
                                                       : hrp_pkg::TAG_LENVAL;
        end
      end
      hrp_pkg::PH_HEADER: begin
        tag = hrp_pkg::TAG_TEXT;
        if (eol) begin
          st.name_pos   = 5'd0;
          st.line_start = (data_byte_i == hrp_pkg::CHAR_LF);
          tag           = hrp_pkg::TAG_SEP;
        end else if (state_i.line_start && state_i.name_pos < hrp_pkg::NAME_LEN) begin
          if (data_byte_i == hrp_pkg::len_name_char(state_i.name_pos[3:0])) begin
            st.name_pos = state_i.name_pos + 5'd1;
            if (st.name_pos == hrp_pkg::NAME_LEN) begin
              st.phase      = hrp_pkg::PH_LENVAL;
              st.name_pos   = 5'd0;
              st.line_start = 1'b0;
            end
          end else begin
            st.name_pos   = 5'd0;
            st.line_start = 1'b0;
          end
        end
      end
      default: begin
        tag = hrp_pkg::TAG_DISCARD;
      end
    endcase
  end

  // crlfcrlf tracker: cr expected at even positions, lf at odd ones
  assign term_char  = state_i.term_pos[0] ? hrp_pkg::CHAR_LF : hrp_pkg::CHAR_CR;
  assign term_match = (data_byte_i == term_char);

  always_comb begin
    state_o          = st;
    result_o.tag     = tag;
    result_o.done    = 1'b0;
    result_o.err     = hrp_pkg::ERR_NONE;
    result_o.root    = 1'b0;
    result_o.cgi     = 1'b0;
    state_o.term_pos = term_match ? state_i.term_pos + 2'd1
                                  : {1'b0, data_byte_i == hrp_pkg::CHAR_CR};
    if (term_match && state_i.term_pos == 2'(hrp_pkg::TermLen - 1)) begin
      result_o.done = 1'b1;
      result_o.err  = st.held_err;
      if (st.held_err == hrp_pkg::ERR_NONE) begin
        result_o.root = (st.root == hrp_pkg::ROOT_SLASH);
        result_o.cgi  = (st.prefix_pos == hrp_pkg::PREFIX_LEN);
      end
      state_o = hrp_pkg::STATE_RESET;
    end
  end

endmodule

### hw/rtl/hrp_checker.sv
// port-level checks on the tagged item channel of the header parser
// depends on hrp_pkg; bound to http_request_header_parser below
module hrp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] byte_tag_i,
  input logic       request_done_i,
  input logic [1:0] error_code_i,
  input logic       target_is_root_i,
  input logic       target_is_cgi_i
);

  // an error only travels with the closing item
  ap_err_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && error_code_i != hrp_pkg::ERR_NONE |-> request_done_i)
    else $error("error code without request done");

  // target flags only on a clean finish
  ap_flags_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (target_is_root_i || target_is_cgi_i) |->
      request_done_i && error_code_i == hrp_pkg::ERR_NONE)
    else $error("target flag outside clean finish");

  // a lone slash cannot also carry the cgi prefix
  ap_root_cgi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(target_is_root_i && target_is_cgi_i))
    else $error("root and cgi both set");

  // overflow item is always discarded
  ap_limit_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && error_code_i == hrp_pkg::ERR_LIMIT |-> byte_tag_i == hrp_pkg::TAG_DISCARD)
    else $error("overflow item not discarded");

  // stalled item holds
  ap_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(byte_tag_i)
      && $stable(request_done_i) && $stable(error_code_i))
    else $error("stalled item changed");

endmodule

bind http_request_header_parser hrp_checker u_hrp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (tag_o.valid),
  .out_ready_i      (tag_o.ready),
  .byte_tag_i       (tag_o.byte_tag),
  .request_done_i   (tag_o.request_done),
  .error_code_i     (tag_o.error_code),
  .target_is_root_i (tag_o.target_is_root),
  .target_is_cgi_i  (tag_o.target_is_cgi)
);
